[design/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Sizes, opcode and status codes, the command item passed from the front
// end to the back end, and circular index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  // Storage size and item widths
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = PTR_W + 1;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;

  // Stream data widths, padded to whole bytes
  localparam int IN_USED_W   = OPCODE_W + DATA_WIDTH;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = STATUS_W + DATA_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Command queue between front and back end
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_LIST       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]          opcode;
    logic signed [DATA_WIDTH-1:0] value;
  } cmd_t;

  // pos + add modulo DEPTH; pos < DEPTH and add <= DEPTH, so one subtract
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] pos,
                                                input logic [CNT_W-1:0] add);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, pos} + SUM_W'(add);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // pos - 1 modulo DEPTH
  function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] pos);
    logic [PTR_W-1:0] res;
    if (pos == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = pos - PTR_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/dq_front.sv]
// ----------------------------------------------------------------------------
// dq_front: input side of the double-ended queue
// Takes stream items, drops undefined opcodes and holds the rest in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [dq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output dq_pkg::cmd_t                       cmd
);

  dq_pkg::cmd_t                  fifo [dq_pkg::CQ_DEPTH];
  logic [dq_pkg::CQ_PTR_W-1:0]   wr_ptr;
  logic [dq_pkg::CQ_PTR_W-1:0]   rd_ptr;
  logic [dq_pkg::CQ_CNT_W-1:0]   fill;
  dq_pkg::cmd_t                  in_cmd;
  logic                          in_acc;
  logic                          op_known;
  logic                          enq;
  logic                          deq;

  always_comb begin
    in_cmd.opcode = s_axis_tdata[dq_pkg::OPCODE_W-1:0];
    in_cmd.value  = $signed(s_axis_tdata[dq_pkg::OPCODE_W +: dq_pkg::DATA_WIDTH]);
  end

  always_comb begin
    unique case (in_cmd.opcode) inside
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK, dq_pkg::OP_POP_FRONT,
      dq_pkg::OP_POP_BACK, dq_pkg::OP_LIST: op_known = 1'b1;
      default:                              op_known = 1'b0;
    endcase
  end

  assign s_axis_tready = (fill != dq_pkg::CQ_CNT_W'(dq_pkg::CQ_DEPTH));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign enq           = in_acc && op_known;   // undefined opcodes vanish here
  assign cmd_valid     = (fill != '0);
  assign deq           = cmd_valid && cmd_ready;
  assign cmd           = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == dq_pkg::CQ_PTR_W'(dq_pkg::CQ_DEPTH - 1)) ? '0
                                                                      : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == dq_pkg::CQ_PTR_W'(dq_pkg::CQ_DEPTH - 1)) ? '0
                                                                      : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        fill <= fill + 1'b1;
      end else if (deq && !enq) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      fifo[wr_ptr] <= in_cmd;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= dq_pkg::CQ_CNT_W'(dq_pkg::CQ_DEPTH))
    else $error("command queue overfilled");

  a_drop_unknown: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !op_known && !deq) |=> (fill == $past(fill)))
    else $error("undefined opcode entered the command queue");

endmodule

`default_nettype wire

[design/dq_back.sv]
// ----------------------------------------------------------------------------
// dq_back: execution side of the double-ended queue
// Owns the circular entry store and its pointers, runs push, pop and list
// commands, and holds one result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  output logic                                cmd_ready,
  input  wire dq_pkg::cmd_t                   cmd,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [dq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;  // pop: read issued, result next
  localparam logic [1:0] S_LRD  = 2'd2;  // list: issue read of entry idx
  localparam logic [1:0] S_LOUT = 2'd3;  // list: emit entry idx

  logic [1:0]                          state, state_next;
  logic [dq_pkg::PTR_W-1:0]            front, front_next;
  logic [dq_pkg::CNT_W-1:0]            count, count_next;
  logic [dq_pkg::CNT_W-1:0]            idx, idx_next;

  logic signed [dq_pkg::DATA_WIDTH-1:0] mem [dq_pkg::DEPTH];
  logic signed [dq_pkg::DATA_WIDTH-1:0] rd_data;
  logic                                 rd_en, wr_en;
  logic [dq_pkg::PTR_W-1:0]             rd_addr, wr_addr;

  logic                                 out_valid;
  logic [dq_pkg::STATUS_W-1:0]          out_status;
  logic signed [dq_pkg::DATA_WIDTH-1:0] out_data;
  logic                                 out_last;

  logic                                 slot_free;
  logic                                 load;
  logic [dq_pkg::STATUS_W-1:0]          ld_status;
  logic signed [dq_pkg::DATA_WIDTH-1:0] ld_data;
  logic                                 ld_last;
  logic                                 is_full, is_empty;
  logic                                 idx_last;

  assign slot_free = !out_valid || m_axis_tready;
  assign is_full   = (count == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign is_empty  = (count == '0);
  assign idx_last  = (idx == count - dq_pkg::CNT_W'(1));

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    cmd_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = front;
    wr_en      = 1'b0;
    wr_addr    = front;
    load       = 1'b0;
    ld_status  = dq_pkg::ST_OK;
    ld_data    = '0;
    ld_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.opcode) inside
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              if (slot_free) begin
                cmd_ready = 1'b1;
                load      = 1'b1;
                if (is_full) begin
                  ld_status = dq_pkg::ST_FULL;
                end else begin
                  wr_en      = 1'b1;
                  count_next = count + 1'b1;
                  if (cmd.opcode == dq_pkg::OP_PUSH_FRONT) begin
                    front_next = dq_pkg::wrap_dec(front);
                    wr_addr    = front_next;
                  end else begin
                    wr_addr = dq_pkg::wrap_add(front, count);
                  end
                end
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                if (slot_free) begin
                  cmd_ready = 1'b1;
                  load      = 1'b1;
                  ld_status = dq_pkg::ST_EMPTY;
                end
              end else begin
                cmd_ready  = 1'b1;
                rd_en      = 1'b1;
                count_next = count - 1'b1;
                state_next = S_READ;
                if (cmd.opcode == dq_pkg::OP_POP_FRONT) begin
                  rd_addr    = front;
                  front_next = dq_pkg::wrap_add(front, dq_pkg::CNT_W'(1));
                end else begin
                  rd_addr = dq_pkg::wrap_add(front, count - dq_pkg::CNT_W'(1));
                end
              end
            end
            dq_pkg::OP_LIST: begin
              if (is_empty) begin
                if (slot_free) begin
                  cmd_ready = 1'b1;
                  load      = 1'b1;
                  ld_status = dq_pkg::ST_EMPTY;
                end
              end else begin
                cmd_ready  = 1'b1;
                idx_next   = '0;
                state_next = S_LRD;
              end
            end
            default: begin
              cmd_ready = 1'b1;  // filtered upstream; drain if ever seen
            end
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_data    = rd_data;
          state_next = S_IDLE;
        end
      end
      S_LRD: begin
        rd_en      = 1'b1;
        rd_addr    = dq_pkg::wrap_add(front, idx);
        state_next = S_LOUT;
      end
      S_LOUT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_data = rd_data;
          ld_last = idx_last;
          if (idx_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_LRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= ld_status;
      out_data   <= ld_data;
      out_last   <= ld_last;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = dq_pkg::OUT_TDATA_W'({out_data, out_status});
  assign m_axis_tlast  = out_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LRD || state == S_LOUT) |-> (count != '0))
    else $error("list running on an empty queue");

  a_list_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOUT) |-> (idx < count))
    else $error("list index past the back entry");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid && cmd_ready && !is_full &&
     (cmd.opcode == dq_pkg::OP_PUSH_FRONT || cmd.opcode == dq_pkg::OP_PUSH_BACK))
    |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the queue");

endmodule

`default_nettype wire

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed values on a circular store
// Stream in commands (push front/back, pop front/back, list), stream out
// status results with popped or listed data.
// ----------------------------------------------------------------------------
// Each input item carries an opcode and a value. Push and pop give one
// result (status ok, empty or full; pops return the removed value). A push
// into a full queue is refused with the full status and stores nothing; a
// pop or list on an empty queue gives one empty result. List streams every
// stored value front to back, tlast on the back entry. Undefined opcodes
// (5..7) are accepted and give no result. A pop reads the entry store
// through its single registered read port before its result is loaded;
// a list reads and emits each stored entry in turn through that port.
// A two-entry command queue in front takes input while the back end works
// or the output is stalled, until it is full; the output register holds one result.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input items
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [2:0] opcode, [34:3] value, [39:35] zero
  input  wire logic [dq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // result items
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: [1:0] status, [33:2] data, [39:34] zero
  output logic [dq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);

  // front -> back command channel
  logic         cmd_valid;
  logic         cmd_ready;
  dq_pkg::cmd_t cmd;

  // front end: decode, drop undefined opcodes, queue commands
  dq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // back end: entry store, pointers, list sequencer, output register
  dq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
